// ===== rtl/dcg_pkg.sv =====
// Shared types, codes and helper functions for the decaying coverage grid.
// Used by every module of the block but dcg_ram; depends on nothing else.
`default_nettype none

package dcg_pkg;

    // Field and register widths fixed by the item formats.
    localparam int ACC_W      = 48;
    localparam int LEVEL_W    = 17;
    localparam int POS_W      = 32;
    localparam int WIDTH_W    = 31;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Action codes carried in the input tuser field.
    localparam logic [ACT_W-1:0] ACT_VISIT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DECAY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SUM   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_ONLY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP   = 2'd3;

    // Level of a freshly visited cell (1.0 in Q1.16) and accumulator ceiling.
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;
    localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};

    // One classified command as it sits in the queue.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } cmd_t;

    // Configuration register set.
    typedef struct packed {
        logic               border_only;
        logic [WIDTH_W-1:0] cell_width_x;
        logic [WIDTH_W-1:0] cell_width_y;
        logic [LEVEL_W-1:0] decay_step;
    } cfg_t;

    // Status from the back part to the front part.
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_stat_t;

    // Magnitude of a signed position; the most negative value maps to 2^31.
    function automatic logic [POS_W-1:0] pos_mag(input logic [POS_W-1:0] pos);
        pos_mag = pos[POS_W-1] ? (~pos + 1'b1) : pos;
    endfunction

    // A cell width of zero behaves as a width of one.
    function automatic logic [WIDTH_W-1:0] width_fix(input logic [WIDTH_W-1:0] w);
        width_fix = (w == '0) ? WIDTH_W'(1) : w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/decaying_coverage_grid.sv =====
// Top level of the decaying coverage grid: configuration registers, front
// queue and back execution unit. Depends on dcg_pkg, dcg_front, dcg_back.
//
//  Channel  Direction  Handshake            Payload
//  s_*      in         s_tvalid / s_tready  tdata: pos_x, pos_y; tuser: action
//  m_*      out        m_tvalid / m_tready  tdata: grid_sum_total; tuser: cell_hit
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A visit runs two 32-step divisions on one shared divider.
// Decay and sum walk every cell, one cell a cycle through the RAM port;
// a clear zeroes every cell, one cell written a cycle.
// After reset the store is zeroed with s_tready low.
// A two-entry queue and the output register let either side stall on its own.
`default_nettype none

module decaying_coverage_grid #(
    parameter int GRID_X = 10,
    parameter int GRID_Y = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [2*dcg_pkg::POS_W-1:0]    s_tdata,    // pos_x [31:0], pos_y [63:32]
    input  wire logic [dcg_pkg::ACT_W-1:0]      s_tuser,    // action [1:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [dcg_pkg::ACC_W-1:0]      m_tdata,    // grid_sum_total [47:0]
    output logic                                m_tuser,    // cell_hit [0]
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcg_pkg::CFG_DATA_W-1:0] cfg_data
);

    import dcg_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    cmd_t       cmd;
    logic       cmd_valid;
    back_stat_t stat;

    // Configuration writes are taken at any time.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BORDER_ONLY:  cfg_next.border_only  = cfg_data[0];
                REG_CELL_WIDTH_X: cfg_next.cell_width_x = cfg_data[WIDTH_W-1:0];
                REG_CELL_WIDTH_Y: cfg_next.cell_width_y = cfg_data[WIDTH_W-1:0];
                REG_DECAY_STEP:   cfg_next.decay_step   = cfg_data[LEVEL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.border_only  <= 1'b0;
            cfg_reg.cell_width_x <= WIDTH_W'(32768);
            cfg_reg.cell_width_y <= WIDTH_W'(32768);
            cfg_reg.decay_step   <= LEVEL_W'(33);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .stat      (stat)
    );

    dcg_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/dcg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module dcg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 100
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/dcg_div.sv =====
// Restoring divider, one quotient bit per cycle, for binning a position magnitude.
// Depends on dcg_pkg.
`default_nettype none

module dcg_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dcg_pkg::POS_W-1:0]   dividend,
    input  wire logic [dcg_pkg::WIDTH_W-1:0] divisor,
    output logic                             done,
    output logic      [dcg_pkg::POS_W-1:0]   quotient
);

    import dcg_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WIDTH_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0]   quo_reg, quo_next;
    logic [WIDTH_W-1:0] dvs_reg, dvs_next;
    logic [WIDTH_W:0]   trial;
    logic               fits;

    // One trial subtraction of the shifted remainder.
    assign trial = {rem_reg, quo_reg[POS_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? WIDTH_W'(trial - {1'b0, dvs_reg}) : trial[WIDTH_W-1:0];
            quo_next = {quo_reg[POS_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(POS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/dcg_front.sv =====
// Front part: accepts input transactions, decodes them into commands and
// holds them in a two-entry queue for the back part. Depends on dcg_pkg.
`default_nettype none

module dcg_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [2*dcg_pkg::POS_W-1:0] s_tdata,
    input  wire logic [dcg_pkg::ACT_W-1:0]   s_tuser,
    output dcg_pkg::cmd_t                    cmd,
    output logic                             cmd_valid,
    input  wire dcg_pkg::back_stat_t         stat
);

    import dcg_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    cmd_t       in_cmd;

    // Decode the incoming transaction into a command.
    always_comb
    begin
        in_cmd.action = s_tuser;
        in_cmd.pos_x  = s_tdata[POS_W-1:0];
        in_cmd.pos_y  = s_tdata[2*POS_W-1:POS_W];
    end

    // Nothing enters while the grid store is being cleared after reset.
    assign s_tready = (count_reg != 2'd2) && !stat.init_busy;
    assign push     = s_tvalid && s_tready;
    assign pop      = stat.pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign cmd       = q_reg[rd_ptr_reg];
    assign cmd_valid = (count_reg != 2'd0);

endmodule

`default_nettype wire

// ===== rtl/dcg_back.sv =====
// Back part: carries out queued commands on the cell store, owns the
// accumulator and the output register. Depends on dcg_pkg, dcg_div, dcg_ram.
`default_nettype none

module dcg_back #(
    parameter int GRID_X = 10,
    parameter int GRID_Y = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dcg_pkg::cfg_t             cfg,
    input  wire dcg_pkg::cmd_t             cmd,
    input  wire logic                      cmd_valid,
    output dcg_pkg::back_stat_t            stat,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [dcg_pkg::ACC_W-1:0] m_tdata,
    output logic                           m_tuser
);

    import dcg_pkg::*;

    localparam int NCELLS = GRID_X * GRID_Y;
    localparam int AW     = $clog2(NCELLS);
    localparam int CNTW   = $clog2(NCELLS + 1);
    localparam int XW     = $clog2(GRID_X);
    localparam int YW     = $clog2(GRID_Y);
    localparam int SUMW   = LEVEL_W + AW;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIVX  = 3'd2;
    localparam logic [2:0] ST_DIVY  = 3'd3;
    localparam logic [2:0] ST_VISIT = 3'd4;
    localparam logic [2:0] ST_WALK  = 3'd5;
    localparam logic [2:0] ST_CLR   = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    paddr_reg, paddr_next;
    cmd_t             cmd_reg, cmd_next;
    logic             bx_ok_reg, bx_ok_next;
    logic [XW-1:0]    bx_reg, bx_next;
    logic [SUMW-1:0]  sum_reg, sum_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;
    logic [ACC_W-1:0] out_data_reg, out_data_next;
    logic             out_hit_reg, out_hit_next;

    logic               div_start;
    logic [POS_W-1:0]   div_dividend;
    logic [WIDTH_W-1:0] div_divisor;
    logic               div_done;
    logic [POS_W-1:0]   div_quo;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [LEVEL_W-1:0] ram_wdata;
    logic [LEVEL_W-1:0] ram_rdata;

    logic               by_ok;
    logic [YW-1:0]      by_bin;
    logic               edge_cell;
    logic               cell_tracked;
    logic [AW-1:0]      cell_addr;
    logic [LEVEL_W-1:0] decayed;
    logic [ACC_W:0]     acc_sum;
    logic               out_free;

    dcg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    dcg_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (NCELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Binning of the y axis straight from the divider, then the cell check.
    assign by_ok = (!cmd_reg.pos_y[POS_W-1] || div_quo == '0)
                   && (div_quo < POS_W'(GRID_Y));
    assign by_bin = div_quo[YW-1:0];
    assign edge_cell = (bx_reg == '0) || (by_bin == '0)
                       || (bx_reg == XW'(GRID_X - 1)) || (by_bin == YW'(GRID_Y - 1));
    assign cell_tracked = bx_ok_reg && by_ok && (!cfg.border_only || edge_cell);
    assign cell_addr = AW'(bx_reg) * AW'(GRID_Y) + AW'(by_bin);

    // Decay of one level and saturating update of the accumulator.
    assign decayed  = (ram_rdata > cfg.decay_step) ? (ram_rdata - cfg.decay_step) : '0;
    assign acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(sum_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        paddr_next     = cnt_reg[AW-1:0];
        cmd_next       = cmd_reg;
        bx_ok_next     = bx_ok_reg;
        bx_next        = bx_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_hit_next   = out_hit_reg;
        div_start      = 1'b0;
        div_dividend   = pos_mag(cmd.pos_x);
        div_divisor    = width_fix(cfg.cell_width_x);
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[AW-1:0];
        ram_wdata      = '0;
        stat.pop       = 1'b0;
        stat.init_busy = (state_reg == ST_INIT);

        unique case (state_reg) inside
            // Zero the store, one cell per cycle.
            ST_INIT, ST_CLR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NCELLS - 1))
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_EMIT;
                end
            end

            // Take the next command and start its work.
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    stat.pop = 1'b1;
                    cmd_next = cmd;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    sum_next = '0;
                    unique case (cmd.action) inside
                        ACT_VISIT:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIVX;
                        end
                        ACT_DECAY, ACT_SUM:
                        begin
                            state_next = ST_WALK;
                        end
                        ACT_CLEAR:
                        begin
                            acc_next   = '0;
                            state_next = ST_CLR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Bin along x, then start y on the shared divider.
            ST_DIVX:
            begin
                if (div_done)
                begin
                    bx_ok_next   = (!cmd_reg.pos_x[POS_W-1] || div_quo == '0)
                                   && (div_quo < POS_W'(GRID_X));
                    bx_next      = div_quo[XW-1:0];
                    div_start    = 1'b1;
                    div_dividend = pos_mag(cmd_reg.pos_y);
                    div_divisor  = width_fix(cfg.cell_width_y);
                    state_next   = ST_DIVY;
                end
            end

            ST_DIVY:
            begin
                if (div_done)
                begin
                    state_next = ST_VISIT;
                end
            end

            // The y quotient is held in the divider; mark the cell if tracked.
            ST_VISIT:
            begin
                hit_next   = cell_tracked;
                ram_we     = cell_tracked;
                ram_waddr  = cell_addr;
                ram_wdata  = LEVEL_ONE;
                state_next = ST_EMIT;
            end

            // Read every cell in turn; decay writes it back in the next cycle.
            ST_WALK:
            begin
                if (cnt_reg < CNTW'(NCELLS))
                begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (cmd_reg.action == ACT_DECAY)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = paddr_reg;
                        ram_wdata = decayed;
                    end
                    else
                    begin
                        sum_next = sum_reg + SUMW'(ram_rdata);
                    end
                end
                if (cnt_reg == CNTW'(NCELLS) && !pend_reg)
                begin
                    if (cmd_reg.action == ACT_SUM)
                    begin
                        acc_next = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end

            // Hand the result to the output register.
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    out_hit_next   = hit_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        paddr_reg    <= paddr_next;
        cmd_reg      <= cmd_next;
        bx_ok_reg    <= bx_ok_next;
        bx_reg       <= bx_next;
        sum_reg      <= sum_next;
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
        out_hit_reg  <= out_hit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

`ifndef SYNTHESIS
    // No command leaves the queue while the store is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> !stat.pop)
    else $error("command popped during the clearing pass");

    // The store is written only by the states that own it.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_INIT || state_reg == ST_CLR
                    || state_reg == ST_VISIT || state_reg == ST_WALK))
    else $error("cell store written from an unexpected state");

    // A divider result only arrives while a visit waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVX || state_reg == ST_DIVY))
    else $error("divider finished outside a visit");

    // The walk counter never runs past the cell count.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(NCELLS))
    else $error("walk counter overran the grid");

    // A result is only loaded into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !m_tready) |=> state_reg == ST_EMIT)
    else $error("result emitted over a waiting transaction");
`endif

endmodule

`default_nettype wire

// ===== verif/dcg_grid_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the decaying coverage grid: tracks register writes and accepted
// commands, predicts every result and compares it with the delivered one.
// Depends on dcg_pkg; instantiated beside the block by the testbench top.
module dcg_grid_checker #(
    parameter int GRID_X = 10,
    parameter int GRID_Y = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [2*dcg_pkg::POS_W-1:0]       s_tdata,    // pos_x [31:0], pos_y [63:32]
    input  logic [dcg_pkg::ACT_W-1:0]         s_tuser,    // action [1:0]
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [dcg_pkg::ACC_W-1:0]         m_tdata,    // grid_sum_total [47:0]
    input  logic                              m_tuser,    // cell_hit [0]
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [dcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                outstanding,
    output int                                fail_count
);

    import dcg_pkg::*;

    localparam int NCELLS = GRID_X * GRID_Y;

    typedef struct packed {
        logic [ACC_W-1:0] total;
        logic             hit;
    } grid_result_t;

    // Shadow copy of the registers and of the grid contents.
    logic               border_mode;
    logic [WIDTH_W-1:0] width_x;
    logic [WIDTH_W-1:0] width_y;
    logic [LEVEL_W-1:0] step_size;
    logic [LEVEL_W-1:0] cell_levels [NCELLS];
    logic [ACC_W-1:0]   running_total;

    grid_result_t       awaited_results [$];
    int                 mismatches;

    // Bins one axis, truncating toward zero; true when the bin lies in [0, span).
    function automatic logic axis_cell(input logic [POS_W-1:0] pos,
                                       input logic [WIDTH_W-1:0] width,
                                       input int span, output int idx);
        logic [POS_W:0] mag;
        logic [POS_W:0] divisor;
        logic [POS_W:0] quot;
        divisor = (width == '0) ? (POS_W+1)'(1) : {2'b00, width};
        mag     = pos[POS_W-1] ? ({1'b1, {POS_W{1'b0}}} - {1'b0, pos}) : {1'b0, pos};
        quot    = mag / divisor;
        idx     = int'(quot);
        if (pos[POS_W-1] && quot != '0)
            return 1'b0;
        return quot < span;
    endfunction

    // Applies one command to the shadow grid and returns the result it causes.
    function automatic grid_result_t advance_grid(input logic [ACT_W-1:0] action,
                                                  input logic [POS_W-1:0] px,
                                                  input logic [POS_W-1:0] py);
        grid_result_t res;
        int           bx;
        int           by;
        logic [63:0]  level_sum;
        res.hit = 1'b0;
        case (action)
            ACT_VISIT:
            begin
                if (axis_cell(px, width_x, GRID_X, bx) && axis_cell(py, width_y, GRID_Y, by))
                begin
                    if (!border_mode || bx == 0 || by == 0 || bx == GRID_X - 1 ||
                        by == GRID_Y - 1)
                    begin
                        cell_levels[bx * GRID_Y + by] = LEVEL_ONE;
                        res.hit = 1'b1;
                    end
                end
            end
            ACT_DECAY:
            begin
                for (int i = 0; i < NCELLS; i++)
                    cell_levels[i] = (cell_levels[i] > step_size) ?
                                     cell_levels[i] - step_size : '0;
            end
            ACT_SUM:
            begin
                level_sum = 64'(running_total);
                for (int i = 0; i < NCELLS; i++)
                    level_sum += 64'(cell_levels[i]);
                if (level_sum > 64'(ACC_MAX))
                    level_sum = 64'(ACC_MAX);
                running_total = level_sum[ACC_W-1:0];
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < NCELLS; i++)
                    cell_levels[i] = '0;
                running_total = '0;
            end
        endcase
        res.total = running_total;
        return res;
    endfunction

    // Follows every transaction on the three channels; results are taken
    // before new commands so that a result can never match a fresh command.
    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t want;
        if (!rst_n)
        begin
            border_mode   = 1'b0;
            width_x       = WIDTH_W'(32768);
            width_y       = WIDTH_W'(32768);
            step_size     = LEVEL_W'(33);
            running_total = '0;
            for (int i = 0; i < NCELLS; i++)
                cell_levels[i] = '0;
            awaited_results.delete();
            mismatches    = 0;
            outstanding  <= 0;
            fail_count   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BORDER_ONLY:  border_mode = cfg_data[0];
                    REG_CELL_WIDTH_X: width_x     = cfg_data[WIDTH_W-1:0];
                    REG_CELL_WIDTH_Y: width_y     = cfg_data[WIDTH_W-1:0];
                    REG_DECAY_STEP:   step_size   = cfg_data[LEVEL_W-1:0];
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: grid_sum_total %0d, cell_hit %0d",
                           m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tdata !== want.total)
                    begin
                        $error("grid_sum_total: expected %0d, actual %0d", want.total, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.hit)
                    begin
                        $error("cell_hit: expected %0d, actual %0d", want.hit, m_tuser);
                        mismatches++;
                    end
                end
            end

            // New predictions join the tail of the queue.
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(),
                                       advance_grid(s_tuser, s_tdata[POS_W-1:0],
                                                    s_tdata[2*POS_W-1:POS_W]));

            outstanding <= awaited_results.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the decaying coverage grid: clock, reset, register set-up,
// directed and random commands with random stalls, and the final verdict.
// Depends on dcg_pkg, decaying_coverage_grid and dcg_grid_checker.
module tb;
    import dcg_pkg::*;

    localparam int GX          = 10;
    localparam int GY          = 10;
    localparam int STALL_LIMIT = 20000;
    localparam int RX_HOLD     = 2000;
    localparam int SETTLE      = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [2*POS_W-1:0]    s_tdata;     // pos_x [31:0], pos_y [63:32]
    logic [ACT_W-1:0]      s_tuser;     // action [1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [ACC_W-1:0]      m_tdata;     // grid_sum_total [47:0]
    logic                  m_tuser;     // cell_hit [0]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   outstanding;
    int   fail_count;
    int   idle_cycles = 0;
    logic quiet = 1'b0;
    logic hold_request = 1'b0;

    always #4 clk = ~clk;

    decaying_coverage_grid #(.GRID_X(GX), .GRID_Y(GY)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dcg_grid_checker #(.GRID_X(GX), .GRID_Y(GY)) grid_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .outstanding(outstanding), .fail_count(fail_count)
    );

    // Watchdog: too long without any transaction ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: a random stall before each transaction, and one long
    // hold-off on request so that the block backs up into its input.
    initial
    begin : result_sink
        int   rx_gap;
        int   rx_hold;
        logic hold_served;
        rx_gap      = 0;
        rx_hold     = 0;
        hold_served = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                rx_hold     = RX_HOLD;
                hold_served = 1'b1;
            end
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap--;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
                rx_gap = quiet ? 0 : $urandom_range(0, 5);
        end
    end

    // Offers one command after a random gap and waits for its transaction.
    task automatic offer_item(input logic [ACT_W-1:0] action,
                              input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {py, px};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes the whole register set back to back.
    task automatic write_regs(input logic bo, input logic [WIDTH_W-1:0] wx,
                              input logic [WIDTH_W-1:0] wy, input logic [LEVEL_W-1:0] step);
        put_reg(REG_BORDER_ONLY, CFG_DATA_W'(bo));
        put_reg(REG_CELL_WIDTH_X, CFG_DATA_W'(wx));
        put_reg(REG_CELL_WIDTH_Y, CFG_DATA_W'(wy));
        put_reg(REG_DECAY_STEP, CFG_DATA_W'(step));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Position mostly inside or just around the grid, sometimes anything at all.
    function automatic logic [POS_W-1:0] pick_pos(input logic [WIDTH_W-1:0] width,
                                                  input int span);
        longint w;
        longint v;
        int     r;
        w = (width == '0) ? 64'sd1 : longint'(width);
        r = $urandom_range(0, 99);
        if (r < 75)
            v = longint'($urandom_range(0, span - 1)) * w + longint'($urandom) % w;
        else if (r < 85)
            v = -(longint'($urandom) % w);
        else if (r < 90)
            v = longint'(span) * w + longint'($urandom) % w;
        else
            return $urandom;
        if (v > 64'sh7FFF_FFFF || v < -64'sh8000_0000)
            return $urandom;
        return v[POS_W-1:0];
    endfunction

    // One random phase under a fresh register setting.
    task automatic run_phase(input logic bo, input logic [WIDTH_W-1:0] wx,
                             input logic [WIDTH_W-1:0] wy, input logic [LEVEL_W-1:0] step,
                             input int count, input logic calm, input int hold_at);
        int               pick;
        logic [ACT_W-1:0] action;
        wait_drained();
        write_regs(bo, wx, wy, step);
        quiet = calm;
        for (int k = 0; k < count; k++)
        begin
            if (k == hold_at)
                hold_request = 1'b1;
            pick   = $urandom_range(0, 99);
            action = (pick < 60) ? ACT_VISIT : (pick < 80) ? ACT_DECAY :
                     (pick < 95) ? ACT_SUM : ACT_CLEAR;
            offer_item(action, pick_pos(wx, GX), pick_pos(wy, GY));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_VISIT;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BORDER_ONLY;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: corners, extremes, truncation of small negatives.
        offer_item(ACT_VISIT, 32'd0, 32'd0);
        offer_item(ACT_VISIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer_item(ACT_VISIT, 32'h8000_0000, 32'h8000_0000);
        offer_item(ACT_VISIT, 32'hFFFF_FFFF, -32'sd32767);
        offer_item(ACT_VISIT, -32'sd32768, 32'd0);
        offer_item(ACT_VISIT, 32'(9 * 32768 + 32767), 32'(5 * 32768));
        offer_item(ACT_VISIT, 32'(10 * 32768), 32'd0);
        offer_item(ACT_VISIT, 32'(3 * 32768 + 5), 32'(4 * 32768));
        offer_item(ACT_SUM, 32'd0, 32'd0);
        offer_item(ACT_DECAY, 32'd0, 32'd0);
        offer_item(ACT_SUM, 32'd0, 32'd0);
        offer_item(ACT_CLEAR, 32'd0, 32'd0);
        offer_item(ACT_SUM, 32'd0, 32'd0);

        // Border mode, zero width on x, widest width on y, full decay step.
        wait_drained();
        write_regs(1'b1, '0, 31'h7FFF_FFFF, LEVEL_ONE);
        offer_item(ACT_VISIT, 32'd5, 32'd0);
        offer_item(ACT_VISIT, 32'd5, 32'h7FFF_FFFF);
        offer_item(ACT_VISIT, 32'd9, 32'h7FFF_FFFF);
        offer_item(ACT_VISIT, 32'd10, 32'd3);
        offer_item(ACT_SUM, 32'd0, 32'd0);
        offer_item(ACT_DECAY, 32'd0, 32'd0);
        offer_item(ACT_SUM, 32'd0, 32'd0);

        // Mode change mid-trial: an interior level keeps decaying and counting.
        wait_drained();
        write_regs(1'b0, 31'd65536, 31'd65536, '0);
        offer_item(ACT_VISIT, 32'(4 * 65536), 32'(4 * 65536));
        wait_drained();
        write_regs(1'b1, 31'd65536, 31'd65536, LEVEL_W'(1));
        offer_item(ACT_DECAY, 32'd0, 32'd0);
        offer_item(ACT_SUM, 32'd0, 32'd0);
        offer_item(ACT_VISIT, 32'(4 * 65536), 32'(4 * 65536));
        offer_item(ACT_CLEAR, 32'd0, 32'd0);

        // Random phases over several settings, the extremes among them.
        run_phase(1'b0, 31'd32768, 31'd32768, LEVEL_W'(33), 200, 1'b0, -1);
        run_phase(1'b1, 31'd65536, 31'd98304, LEVEL_W'(1000), 200, 1'b0, 50);
        run_phase(1'b0, '0, 31'd1, LEVEL_ONE, 100, 1'b1, -1);
        run_phase(1'b1, 31'h7FFF_FFFF, 31'h0CCC_CCCC, '0, 150, 1'b0, -1);
        run_phase(1'b0, 31'h0C00_0000, 31'd7, LEVEL_W'(12345), 200, 1'b0, -1);
        for (int p = 0; p < 4; p++)
            run_phase(1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? WIDTH_W'($urandom_range(0, 1 << 18)) :
                                             WIDTH_W'($urandom),
                      $urandom_range(0, 1) ? WIDTH_W'($urandom_range(0, 1 << 18)) :
                                             WIDTH_W'($urandom),
                      LEVEL_W'($urandom_range(0, 65536)), 100, p[0], -1);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
